// ===== rtl/tcw_pkg.sv =====
package tcw_pkg;

  // Character codes with a meaning of their own.
  localparam logic [7:0] CH_SPACE   = 8'h20;
  localparam logic [7:0] CH_NEWLINE = 8'h0A;

  // Attribute used after reset, both for the register and the screen fill.
  localparam logic [7:0]  RESET_COLOR = 8'h4F;
  localparam logic [15:0] RESET_BLANK = {RESET_COLOR, CH_SPACE};

  // Operation codes carried on the input side.
  localparam logic [2:0] FUNC_PUT_CHAR  = 3'd0;
  localparam logic [2:0] FUNC_WRITE     = 3'd1;
  localparam logic [2:0] FUNC_SET_CUR   = 3'd2;
  localparam logic [2:0] FUNC_CLEAR     = 3'd3;
  localparam logic [2:0] FUNC_READ      = 3'd4;

  // Word index of the configuration register.
  localparam logic REG_TEXT_COLOR = 1'b0;

  // Classified operation handed from the front to the back.
  typedef enum logic [2:0] {
    OP_PUT_CHAR,
    OP_NEWLINE,
    OP_WRITE,
    OP_SET_CUR,
    OP_CLEAR,
    OP_READ,
    OP_NOP
  } tcw_kind_t;

  typedef struct packed {
    tcw_kind_t   kind;
    logic [7:0]  ch;
    logic [7:0]  attr;
    logic [6:0]  x;
    logic [4:0]  y;
    logic        in_range;
  } tcw_op_t;

endpackage

// ===== rtl/tcw_ram.sv =====
module tcw_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 2000
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ===== rtl/tcw_front.sv =====
module tcw_front #(
  parameter int COLUMNS = 80,
  parameter int ROWS    = 25
) (
  input  logic            in_tvalid,
  output logic            in_tready,
  input  logic [2:0]      func,
  input  logic [7:0]      char_code,
  input  logic [7:0]      cell_color,
  input  logic [6:0]      pos_x,
  input  logic [4:0]      pos_y,
  input  logic            q_full,
  input  logic            init_busy,
  output logic            q_push,
  output tcw_pkg::tcw_op_t q_op
);

  import tcw_pkg::*;

  logic x_in, y_in;

  assign in_tready = !q_full && !init_busy;
  assign q_push    = in_tvalid && in_tready;

  assign x_in = 8'(pos_x) < 8'(COLUMNS);
  assign y_in = 7'(pos_y) < 7'(ROWS);

  always_comb begin
    q_op.ch       = char_code;
    q_op.attr     = cell_color;
    q_op.x        = pos_x;
    q_op.y        = pos_y;
    q_op.in_range = x_in && y_in;
    case (func)
      FUNC_PUT_CHAR: begin
        q_op.kind = (char_code == CH_NEWLINE) ? OP_NEWLINE : OP_PUT_CHAR;
      end
      FUNC_WRITE: begin
        q_op.kind = OP_WRITE;
      end
      FUNC_SET_CUR: begin
        // The cursor saturates: column to one past the edge, row to the last.
        q_op.kind = OP_SET_CUR;
        if (8'(pos_x) > 8'(COLUMNS)) begin
          q_op.x = 7'(COLUMNS);
        end
        if (7'(pos_y) > 7'(ROWS - 1)) begin
          q_op.y = 5'(ROWS - 1);
        end
      end
      FUNC_CLEAR: begin
        q_op.kind = OP_CLEAR;
      end
      FUNC_READ: begin
        q_op.kind = OP_READ;
      end
      default: begin
        q_op.kind = OP_NOP;
      end
    endcase
  end

endmodule

// ===== rtl/tcw_queue.sv =====
module tcw_queue #(
  parameter int DEPTH = 2
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  tcw_pkg::tcw_op_t push_op,
  output logic             full,
  input  logic             pop,
  output logic             valid,
  output tcw_pkg::tcw_op_t head_op
);

  import tcw_pkg::*;

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int NW = $clog2(DEPTH + 1);

  tcw_op_t         slot_r [DEPTH];
  logic [PW-1:0]   wr_ptr_r, rd_ptr_r;
  logic [NW-1:0]   count_r;

  assign full    = count_r == NW'(DEPTH);
  assign valid   = count_r != '0;
  assign head_op = slot_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) begin
        slot_r[wr_ptr_r] <= push_op;
        wr_ptr_r <= (wr_ptr_r == PW'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
      end
      if (pop) begin
        rd_ptr_r <= (rd_ptr_r == PW'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
      end
      if (push && !pop) begin
        count_r <= count_r + 1'b1;
      end else if (pop && !push) begin
        count_r <= count_r - 1'b1;
      end
    end
  end

endmodule

// ===== rtl/tcw_back.sv =====
module tcw_back #(
  parameter int COLUMNS = 80,
  parameter int ROWS    = 25
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic [7:0]                          text_color,
  input  logic                                q_valid,
  input  tcw_pkg::tcw_op_t                    q_op,
  output logic                                q_pop,
  output logic                                init_busy,
  output logic                                ram_we,
  output logic [$clog2(COLUMNS*ROWS)-1:0]     ram_waddr,
  output logic [15:0]                         ram_wdata,
  output logic                                ram_re,
  output logic [$clog2(COLUMNS*ROWS)-1:0]     ram_raddr,
  input  logic [15:0]                         ram_rdata,
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic [6:0]                          out_col,
  output logic [4:0]                          out_line,
  output logic [15:0]                         out_cell,
  output logic                                out_scrolled
);

  import tcw_pkg::*;

  localparam int CELLS = COLUMNS * ROWS;
  localparam int AW    = $clog2(CELLS);
  localparam int CW    = $clog2(COLUMNS + 1);
  localparam int RW    = (ROWS > 2) ? $clog2(ROWS) : 1;

  typedef enum logic [2:0] {
    ST_INIT,
    ST_IDLE,
    ST_READ,
    ST_FILL,
    ST_SCROLL,
    ST_FINISH
  } state_t;

  state_t         state_r, state_nxt;
  logic [AW-1:0]  sweep_r, sweep_nxt;
  logic [CW-1:0]  cur_col_r, cur_col_nxt;
  logic [RW-1:0]  cur_row_r, cur_row_nxt;
  logic [15:0]    blank_r, blank_nxt;
  logic           pend_we_r, pend_we_nxt;
  logic [AW-1:0]  pend_addr_r, pend_addr_nxt;
  logic [15:0]    pend_data_r, pend_data_nxt;
  logic           pend_scroll_r, pend_scroll_nxt;
  logic           out_valid_r, out_valid_nxt;
  logic [6:0]     out_col_r, out_col_nxt;
  logic [4:0]     out_line_r, out_line_nxt;
  logic [15:0]    out_cell_r, out_cell_nxt;
  logic           out_scrolled_r, out_scrolled_nxt;

  logic           is_nl, is_put, wrap, at_bottom, pc_scroll, room, sweep_last;
  logic [CW-1:0]  pc_col, col_sel;
  logic [RW-1:0]  pc_row, row_sel;
  logic [AW-1:0]  cell_addr;
  logic [AW:0]    scroll_rd;
  logic [15:0]    put_cell;

  // Put-char cursor movement, worked out from the current cursor.
  assign is_nl     = q_op.kind == OP_NEWLINE;
  assign is_put    = is_nl || (q_op.kind == OP_PUT_CHAR);
  assign wrap      = is_nl || (cur_col_r >= CW'(COLUMNS));
  assign at_bottom = cur_row_r >= RW'(ROWS - 1);
  assign pc_scroll = wrap && at_bottom;
  assign pc_col    = wrap ? '0 : cur_col_r;
  assign pc_row    = !wrap ? cur_row_r : (at_bottom ? RW'(ROWS - 1) : cur_row_r + 1'b1);
  assign put_cell  = {text_color, q_op.ch};

  assign row_sel   = is_put ? pc_row : RW'(q_op.y);
  assign col_sel   = is_put ? pc_col : CW'(q_op.x);
  assign cell_addr = AW'(row_sel) * AW'(COLUMNS) + AW'(col_sel);

  assign scroll_rd  = {1'b0, sweep_r} + (AW + 1)'(COLUMNS + 1);
  assign sweep_last = sweep_r == AW'(CELLS - 1);
  assign room       = !out_valid_r || out_ready;

  assign init_busy    = state_r == ST_INIT;
  assign out_valid    = out_valid_r;
  assign out_col      = out_col_r;
  assign out_line     = out_line_r;
  assign out_cell     = out_cell_r;
  assign out_scrolled = out_scrolled_r;

  always_comb begin
    state_nxt        = state_r;
    sweep_nxt        = sweep_r;
    cur_col_nxt      = cur_col_r;
    cur_row_nxt      = cur_row_r;
    blank_nxt        = blank_r;
    pend_we_nxt      = pend_we_r;
    pend_addr_nxt    = pend_addr_r;
    pend_data_nxt    = pend_data_r;
    pend_scroll_nxt  = pend_scroll_r;
    out_valid_nxt    = out_valid_r && !out_ready;
    out_col_nxt      = out_col_r;
    out_line_nxt     = out_line_r;
    out_cell_nxt     = out_cell_r;
    out_scrolled_nxt = out_scrolled_r;
    q_pop            = 1'b0;
    ram_we           = 1'b0;
    ram_waddr        = sweep_r;
    ram_wdata        = blank_r;
    ram_re           = 1'b0;
    ram_raddr        = cell_addr;

    case (state_r)
      ST_INIT: begin
        ram_we    = 1'b1;
        ram_wdata = RESET_BLANK;
        sweep_nxt = sweep_r + 1'b1;
        if (sweep_last) begin
          sweep_nxt = '0;
          state_nxt = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (q_valid && room) begin
          q_pop = 1'b1;
          case (q_op.kind)
            OP_PUT_CHAR, OP_NEWLINE: begin
              cur_row_nxt = pc_row;
              cur_col_nxt = is_nl ? pc_col : pc_col + 1'b1;
              if (pc_scroll) begin
                // Character lands on the bottom row after the scroll sweep.
                pend_we_nxt     = !is_nl;
                pend_addr_nxt   = cell_addr;
                pend_data_nxt   = put_cell;
                pend_scroll_nxt = 1'b1;
                blank_nxt       = {text_color, CH_SPACE};
                sweep_nxt       = '0;
                ram_re          = 1'b1;
                ram_raddr       = AW'(COLUMNS);
                state_nxt       = ST_SCROLL;
              end else begin
                ram_we    = !is_nl;
                ram_waddr = cell_addr;
                ram_wdata = put_cell;
                out_valid_nxt = 1'b1;
              end
            end
            OP_WRITE: begin
              ram_we        = q_op.in_range;
              ram_waddr     = cell_addr;
              ram_wdata     = {q_op.attr, q_op.ch};
              out_valid_nxt = 1'b1;
            end
            OP_SET_CUR: begin
              cur_col_nxt   = CW'(q_op.x);
              cur_row_nxt   = RW'(q_op.y);
              out_valid_nxt = 1'b1;
            end
            OP_CLEAR: begin
              pend_we_nxt     = 1'b0;
              pend_scroll_nxt = 1'b0;
              blank_nxt       = {text_color, CH_SPACE};
              sweep_nxt       = '0;
              state_nxt       = ST_FILL;
            end
            OP_READ: begin
              if (q_op.in_range) begin
                ram_re    = 1'b1;
                state_nxt = ST_READ;
              end else begin
                out_valid_nxt = 1'b1;
              end
            end
            default: begin
              out_valid_nxt = 1'b1;
            end
          endcase
          out_col_nxt      = 7'(cur_col_nxt);
          out_line_nxt     = 5'(cur_row_nxt);
          out_cell_nxt     = '0;
          out_scrolled_nxt = 1'b0;
        end
      end
      ST_READ: begin
        out_valid_nxt = 1'b1;
        out_cell_nxt  = ram_rdata;
        state_nxt     = ST_IDLE;
      end
      ST_FILL: begin
        ram_we    = 1'b1;
        sweep_nxt = sweep_r + 1'b1;
        if (sweep_last) begin
          state_nxt = ST_FINISH;
        end
      end
      ST_SCROLL: begin
        // Write row-shifted data read in the previous cycle; blank the last row.
        ram_we    = 1'b1;
        ram_wdata = (sweep_r < AW'(CELLS - COLUMNS)) ? ram_rdata : blank_r;
        ram_re    = scroll_rd < (AW + 1)'(CELLS);
        ram_raddr = scroll_rd[AW-1:0];
        sweep_nxt = sweep_r + 1'b1;
        if (sweep_last) begin
          state_nxt = ST_FINISH;
        end
      end
      ST_FINISH: begin
        ram_we           = pend_we_r;
        ram_waddr        = pend_addr_r;
        ram_wdata        = pend_data_r;
        out_valid_nxt    = 1'b1;
        out_col_nxt      = 7'(cur_col_r);
        out_line_nxt     = 5'(cur_row_r);
        out_cell_nxt     = '0;
        out_scrolled_nxt = pend_scroll_r;
        state_nxt        = ST_IDLE;
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_INIT;
      sweep_r     <= '0;
      cur_col_r   <= '0;
      cur_row_r   <= '0;
      pend_we_r   <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      sweep_r     <= sweep_nxt;
      cur_col_r   <= cur_col_nxt;
      cur_row_r   <= cur_row_nxt;
      pend_we_r   <= pend_we_nxt;
      out_valid_r <= out_valid_nxt;
    end
    blank_r        <= blank_nxt;
    pend_addr_r    <= pend_addr_nxt;
    pend_data_r    <= pend_data_nxt;
    pend_scroll_r  <= pend_scroll_nxt;
    out_col_r      <= out_col_nxt;
    out_line_r     <= out_line_nxt;
    out_cell_r     <= out_cell_nxt;
    out_scrolled_r <= out_scrolled_nxt;
  end

`ifndef SYNTHESIS
  a_cursor_range: assert property (@(posedge clk) disable iff (!rst_n)
    (cur_col_r <= CW'(COLUMNS)) && (cur_row_r <= RW'(ROWS - 1)))
    else $error("cursor left the screen");

  a_read_issued: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_READ) |-> $past(ram_re))
    else $error("read result expected without a RAM read");

  a_scroll_bottom: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_scrolled_r) |-> (out_line_r == 5'(ROWS - 1)))
    else $error("scroll reported away from the bottom row");

  a_sweep_no_result: assert property (@(posedge clk) disable iff (!rst_n)
    ((state_r == ST_SCROLL) || (state_r == ST_FILL)) |-> !out_valid_r)
    else $error("result pending while a sweep runs");
`endif

endmodule

// ===== rtl/text_console_writer_top.sv =====
// Text console writer: a character-cell terminal over a COLUMNS x ROWS store
// of 16-bit cells (character in the low byte, attribute in the high byte).
// Operations arrive on the in_ stream, one per transfer, with the operation
// code in in_tuser: put char, write cell, set cursor, clear screen, read
// cell. Every operation returns exactly one transfer on the out_ stream with
// the cursor after the operation, the cell read (zero otherwise) and a flag
// that is set when put char scrolled the screen up one line.
// The APB port holds one register, the text attribute used by put char,
// by the blank bottom row of a scroll and by clear screen.
// An operation passes through the queue and the output register before
// out_tvalid rises; a cell read also waits on the registered RAM read port.
// Operations other than a cell read, a scroll or a clear sustain one
// transfer per cycle while out_tready is high. A scroll or a clear sweeps
// the single-write-port cell RAM one cell per cycle and holds the executor
// throughout; a two-entry queue behind the decoder accepts until it fills.
// After reset the cursor is at the top left, the attribute is 0x4F and a
// clearing pass over every cell fills the screen with spaces in 0x4F;
// in_tready stays low during that pass while register writes are taken.
// When the receiver stalls, the result waits in the output register, then
// the queue fills and in_tready drops; nothing is lost or repeated.
module text_console_writer_top #(
  parameter int COLUMNS = 80,
  parameter int ROWS    = 25
) (
  input  logic        clk,
  input  logic        rst_n,
  // Input stream.
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [31:0] in_tdata,    // char_code[7:0], cell_color[15:8], pos_x[22:16],
                                   // pos_y[27:23], zero[31:28]
  input  logic [2:0]  in_tuser,    // func[2:0]
  // Result stream.
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [31:0] out_tdata,   // cursor_col[6:0], cursor_line[11:7],
                                   // cell_value[27:12], scrolled[28], zero[31:29]
  // Configuration port.
  input  logic        cfg_psel,
  input  logic        cfg_penable,
  input  logic        cfg_pwrite,
  input  logic [2:0]  cfg_paddr,
  input  logic [31:0] cfg_pwdata,
  output logic [31:0] cfg_prdata,
  output logic        cfg_pready
);

  import tcw_pkg::*;

  localparam int CELLS = COLUMNS * ROWS;
  localparam int AW    = $clog2(CELLS);

  logic [7:0]    text_color_r;
  logic          cfg_wr;
  logic          reg_sel;

  tcw_op_t       dec_op, head_op;
  logic          q_push, q_full, q_valid, q_pop, init_busy;

  logic          ram_we, ram_re;
  logic [AW-1:0] ram_waddr, ram_raddr;
  logic [15:0]   ram_wdata, ram_rdata;

  logic [6:0]    res_col;
  logic [4:0]    res_line;
  logic [15:0]   res_cell;
  logic          res_scrolled;

  // Register access: a write completes in the access phase; word index in bit 2.
  assign cfg_pready = 1'b1;
  assign reg_sel    = cfg_paddr[2] == REG_TEXT_COLOR;
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;
  assign cfg_prdata = reg_sel ? {24'd0, text_color_r} : 32'd0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      text_color_r <= RESET_COLOR;
    end else if (cfg_wr && reg_sel) begin
      text_color_r <= cfg_pwdata[7:0];
    end
  end

  // The front decodes each transfer into an operation for the queue.
  tcw_front #(
    .COLUMNS (COLUMNS),
    .ROWS    (ROWS)
  ) u_front (
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .func       (in_tuser),
    .char_code  (in_tdata[7:0]),
    .cell_color (in_tdata[15:8]),
    .pos_x      (in_tdata[22:16]),
    .pos_y      (in_tdata[27:23]),
    .q_full     (q_full),
    .init_busy  (init_busy),
    .q_push     (q_push),
    .q_op       (dec_op)
  );

  tcw_queue #(
    .DEPTH (2)
  ) u_queue (
    .clk     (clk),
    .rst_n   (rst_n),
    .push    (q_push),
    .push_op (dec_op),
    .full    (q_full),
    .pop     (q_pop),
    .valid   (q_valid),
    .head_op (head_op)
  );

  // The back owns the cursor, the cell RAM sweeps and the output register.
  tcw_back #(
    .COLUMNS (COLUMNS),
    .ROWS    (ROWS)
  ) u_back (
    .clk          (clk),
    .rst_n        (rst_n),
    .text_color   (text_color_r),
    .q_valid      (q_valid),
    .q_op         (head_op),
    .q_pop        (q_pop),
    .init_busy    (init_busy),
    .ram_we       (ram_we),
    .ram_waddr    (ram_waddr),
    .ram_wdata    (ram_wdata),
    .ram_re       (ram_re),
    .ram_raddr    (ram_raddr),
    .ram_rdata    (ram_rdata),
    .out_valid    (out_tvalid),
    .out_ready    (out_tready),
    .out_col      (res_col),
    .out_line     (res_line),
    .out_cell     (res_cell),
    .out_scrolled (res_scrolled)
  );

  tcw_ram #(
    .WIDTH (16),
    .DEPTH (CELLS)
  ) u_cells (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  assign out_tdata = {3'd0, res_scrolled, res_cell, res_line, res_col};

endmodule

// ===== sim/testbench.sv =====
`timescale 1ns / 1ps

module testbench;
  import tcw_pkg::*;

  // Screen geometry, passed to the block so that both sides agree.
  localparam int COLS  = 80;
  localparam int ROWS  = 25;
  localparam int CELLS = COLS * ROWS;

  // Operation codes the block does not implement; they must come back as no-ops.
  localparam logic [2:0] FUNC_SPARE_FIRST = 3'd5;
  localparam logic [2:0] FUNC_SPARE_LAST  = 3'd7;

  // A scroll or a clear reports only after its sweep of the whole store, so
  // the block is already idle once every report is in. The extra sweep's
  // length before an attribute write is margin on top of that.
  localparam int SWEEP_CYCLES = CELLS + 8;
  localparam int DRAIN_LIMIT  = 200000;
  localparam int ITEMS_PER_PHASE = 214;

  // Input transfer layout, lowest bits first: char_code, cell_color, pos_x,
  // pos_y, then zero padding.
  typedef struct packed {
    logic [3:0] pad;
    logic [4:0] y;
    logic [6:0] x;
    logic [7:0] attr;
    logic [7:0] ch;
  } console_op_t;

  // Result transfer layout: cursor_col, cursor_line, cell_value, scrolled.
  typedef struct packed {
    logic [2:0]  pad;
    logic        scrolled;
    logic [15:0] cell_word;
    logic [4:0]  line;
    logic [6:0]  col;
  } console_report_t;

  // One row of the opening table. When known is set the expected report is
  // the one typed in the row; otherwise it comes from the predictor.
  typedef struct packed {
    logic [2:0]  func;
    logic [7:0]  ch;
    logic [7:0]  attr;
    logic [6:0]  x;
    logic [4:0]  y;
    logic        known;
    logic [6:0]  col;
    logic [4:0]  line;
    logic [15:0] cell_word;
    logic        scrolled;
  } opening_row_t;

  logic        clk;
  logic        rst_n;
  logic        in_tvalid;
  logic        in_tready;
  logic [31:0] in_tdata;
  logic [2:0]  in_tuser;
  logic        out_tvalid;
  logic        out_tready;
  logic [31:0] out_tdata;
  logic        cfg_psel;
  logic        cfg_penable;
  logic        cfg_pwrite;
  logic [2:0]  cfg_paddr;
  logic [31:0] cfg_pwdata;
  logic [31:0] cfg_prdata;
  logic        cfg_pready;

  // Mirror of the block: the screen store, the cursor and the attribute.
  logic [15:0] screen_mirror [CELLS];
  int          caret_col;
  int          caret_row;
  logic [7:0]  text_color;

  // Reports still owed by the block, oldest first.
  console_report_t cursor_reports_q [$];

  int  error_count = 0;
  int  reports_seen = 0;
  int  burst_left = 0;
  // Set by the receiver while it holds off for a long stretch; the sender
  // then offers transfers back to back so that the block fills up.
  bit  rx_hold = 1'b0;
  bit  long_hold_done = 1'b0;

  // The opening table. It walks through the read and write corners of the
  // store, the saturating cursor, lazy wrap and newline on the last row
  // (both scroll), the spare operation codes and a clear.
  opening_row_t opening_rows [0:28] = '{
    '{FUNC_READ,     8'h00, 8'h00, 7'd0,   5'd0,  1'b1, 7'd0,  5'd0,  16'h4F20, 1'b0},
    '{FUNC_READ,     8'h00, 8'h00, 7'd79,  5'd24, 1'b1, 7'd0,  5'd0,  16'h4F20, 1'b0},
    '{FUNC_READ,     8'h00, 8'h00, 7'd80,  5'd0,  1'b1, 7'd0,  5'd0,  16'h0000, 1'b0},
    '{FUNC_READ,     8'h00, 8'h00, 7'd0,   5'd25, 1'b1, 7'd0,  5'd0,  16'h0000, 1'b0},
    '{FUNC_READ,     8'hFF, 8'hFF, 7'd127, 5'd31, 1'b1, 7'd0,  5'd0,  16'h0000, 1'b0},
    '{FUNC_PUT_CHAR, 8'h41, 8'hFF, 7'd127, 5'd31, 1'b1, 7'd1,  5'd0,  16'h0000, 1'b0},
    '{FUNC_READ,     8'h00, 8'h00, 7'd0,   5'd0,  1'b1, 7'd1,  5'd0,  16'h4F41, 1'b0},
    '{FUNC_PUT_CHAR, CH_NEWLINE, 8'h00, 7'd0, 5'd0, 1'b1, 7'd0, 5'd1, 16'h0000, 1'b0},
    '{FUNC_WRITE,    8'hFF, 8'hFF, 7'd79,  5'd24, 1'b1, 7'd0,  5'd1,  16'h0000, 1'b0},
    '{FUNC_WRITE,    8'h00, 8'h00, 7'd0,   5'd24, 1'b1, 7'd0,  5'd1,  16'h0000, 1'b0},
    '{FUNC_WRITE,    8'h55, 8'hAA, 7'd80,  5'd0,  1'b1, 7'd0,  5'd1,  16'h0000, 1'b0},
    '{FUNC_WRITE,    8'h55, 8'hAA, 7'd127, 5'd31, 1'b1, 7'd0,  5'd1,  16'h0000, 1'b0},
    '{FUNC_READ,     8'h00, 8'h00, 7'd79,  5'd24, 1'b1, 7'd0,  5'd1,  16'hFFFF, 1'b0},
    '{FUNC_READ,     8'h00, 8'h00, 7'd0,   5'd24, 1'b1, 7'd0,  5'd1,  16'h0000, 1'b0},
    '{FUNC_SET_CUR,  8'h00, 8'h00, 7'd127, 5'd31, 1'b1, 7'd80, 5'd24, 16'h0000, 1'b0},
    '{FUNC_PUT_CHAR, 8'h42, 8'h00, 7'd0,   5'd0,  1'b1, 7'd1,  5'd24, 16'h0000, 1'b1},
    '{FUNC_READ,     8'h00, 8'h00, 7'd79,  5'd23, 1'b1, 7'd1,  5'd24, 16'hFFFF, 1'b0},
    '{FUNC_READ,     8'h00, 8'h00, 7'd0,   5'd24, 1'b1, 7'd1,  5'd24, 16'h4F42, 1'b0},
    '{FUNC_SET_CUR,  8'h00, 8'h00, 7'd78,  5'd24, 1'b1, 7'd78, 5'd24, 16'h0000, 1'b0},
    '{FUNC_PUT_CHAR, 8'hFF, 8'h00, 7'd0,   5'd0,  1'b0, 7'd0,  5'd0,  16'h0000, 1'b0},
    '{FUNC_PUT_CHAR, 8'h00, 8'h00, 7'd0,   5'd0,  1'b0, 7'd0,  5'd0,  16'h0000, 1'b0},
    '{FUNC_PUT_CHAR, CH_NEWLINE, 8'h00, 7'd0, 5'd0, 1'b1, 7'd0, 5'd24, 16'h0000, 1'b1},
    '{FUNC_READ,     8'h00, 8'h00, 7'd79,  5'd23, 1'b1, 7'd0,  5'd24, 16'h4F00, 1'b0},
    '{FUNC_SPARE_FIRST, 8'hFF, 8'hFF, 7'd127, 5'd31, 1'b1, 7'd0, 5'd24, 16'h0000, 1'b0},
    '{FUNC_SPARE_LAST,  8'hFF, 8'hFF, 7'd0,   5'd0,  1'b1, 7'd0, 5'd24, 16'h0000, 1'b0},
    '{FUNC_CLEAR,    8'h00, 8'h00, 7'd0,   5'd0,  1'b1, 7'd0,  5'd24, 16'h0000, 1'b0},
    '{FUNC_READ,     8'h00, 8'h00, 7'd79,  5'd23, 1'b1, 7'd0,  5'd24, 16'h4F20, 1'b0},
    '{FUNC_SET_CUR,  8'h00, 8'h00, 7'd80,  5'd0,  1'b1, 7'd80, 5'd0,  16'h0000, 1'b0},
    '{FUNC_PUT_CHAR, 8'h7A, 8'h00, 7'd0,   5'd0,  1'b1, 7'd1,  5'd1,  16'h0000, 1'b0}
  };

  text_console_writer_top #(
    .COLUMNS(COLS),
    .ROWS   (ROWS)
  ) dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_psel   (cfg_psel),
    .cfg_penable(cfg_penable),
    .cfg_pwrite (cfg_pwrite),
    .cfg_paddr  (cfg_paddr),
    .cfg_pwdata (cfg_pwdata),
    .cfg_prdata (cfg_prdata),
    .cfg_pready (cfg_pready)
  );

  always begin
    clk = 1'b0;
    #4;
    clk = 1'b1;
    #4;
  end

  function automatic void report_error(string msg);
    error_count++;
    if (error_count <= 10) begin
      $display("ERROR: %s", msg);
    end
  endfunction

  function automatic void blank_cells(int first, int count);
    for (int i = first; i < first + count; i++) begin
      screen_mirror[i] = {text_color, CH_SPACE};
    end
  endfunction

  // Applies one operation to the mirror and returns the report it causes.
  function automatic console_report_t predict_console(logic [2:0] func, console_op_t op);
    console_report_t rep;
    rep = '0;
    case (func)
      FUNC_PUT_CHAR: begin
        // A pending wrap and a newline both move to the start of the next
        // row; on the last row that means scrolling the store up a line.
        if (caret_col >= COLS || op.ch == CH_NEWLINE) begin
          caret_col = 0;
          if (caret_row >= ROWS - 1) begin
            caret_row = ROWS - 1;
            for (int i = 0; i < CELLS - COLS; i++) begin
              screen_mirror[i] = screen_mirror[i + COLS];
            end
            blank_cells(CELLS - COLS, COLS);
            rep.scrolled = 1'b1;
          end else begin
            caret_row++;
          end
        end
        if (op.ch != CH_NEWLINE) begin
          screen_mirror[caret_row * COLS + caret_col] = {text_color, op.ch};
          caret_col++;
        end
      end
      FUNC_WRITE: begin
        if (op.x < COLS && op.y < ROWS) begin
          screen_mirror[op.y * COLS + op.x] = {op.attr, op.ch};
        end
      end
      FUNC_SET_CUR: begin
        caret_col = (op.x > COLS) ? COLS : int'(op.x);
        caret_row = (op.y > ROWS - 1) ? ROWS - 1 : int'(op.y);
      end
      FUNC_CLEAR: begin
        blank_cells(0, CELLS);
      end
      FUNC_READ: begin
        if (op.x < COLS && op.y < ROWS) begin
          rep.cell_word = screen_mirror[op.y * COLS + op.x];
        end
      end
      default: begin
      end
    endcase
    rep.col  = 7'(caret_col);
    rep.line = 5'(caret_row);
    return rep;
  endfunction

  // Every field drawn at random over its full width.
  function automatic console_op_t scatter_op();
    console_op_t op;
    op      = '0;
    op.ch   = 8'($urandom);
    op.attr = 8'($urandom);
    op.x    = 7'($urandom);
    op.y    = 5'($urandom);
    return op;
  endfunction

  // Between bursts of random length the sender mostly leaves a random gap, except
  // while the receiver is holding off, when it keeps pushing.
  task automatic pace_sender();
    int gap;
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      burst_left = ($urandom_range(0, 5) == 0) ? $urandom_range(60, 150)
                                                : $urandom_range(1, 20);
      if (!rx_hold && $urandom_range(0, 3) != 0) begin
        gap = $urandom_range(1, 6);
        @(negedge clk);
        in_tvalid <= 1'b0;
        repeat (gap - 1) @(negedge clk);
      end
    end
  endtask

  // Offers one operation, waits for its transfer and records what the block
  // owes for it.
  task automatic send_op(logic [2:0] func, console_op_t op, logic known,
                         console_report_t typed_rep);
    console_report_t rep;
    @(negedge clk);
    in_tuser  <= func;
    in_tdata  <= op;
    in_tvalid <= 1'b1;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    rep = predict_console(func, op);
    cursor_reports_q.push_back(known ? typed_rep : rep);
    pace_sender();
  endtask

  // Stops offering and waits until every owed report has come back.
  task automatic settle_console();
    int waited;
    waited = 0;
    @(negedge clk);
    in_tvalid <= 1'b0;
    while (cursor_reports_q.size() != 0 && waited < DRAIN_LIMIT) begin
      @(posedge clk);
      waited++;
    end
  endtask

  // Writes the attribute register over APB and reads it back. The block
  // must be idle, so the last sweep is given time to finish first.
  task automatic write_text_color(logic [7:0] color);
    logic [31:0] readback;
    repeat (SWEEP_CYCLES) @(negedge clk);
    cfg_psel    <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b1;
    cfg_paddr   <= {REG_TEXT_COLOR, 2'b00};
    cfg_pwdata  <= {24'h0, color};
    @(negedge clk);
    cfg_penable <= 1'b1;
    @(posedge clk);
    while (!cfg_pready) @(posedge clk);
    text_color = color;
    @(negedge clk);
    cfg_pwrite  <= 1'b0;
    cfg_penable <= 1'b0;
    @(negedge clk);
    cfg_penable <= 1'b1;
    @(posedge clk);
    while (!cfg_pready) @(posedge clk);
    readback = cfg_prdata;
    @(negedge clk);
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
    if (readback[7:0] != color) begin
      report_error($sformatf("text_color reads back %h, written %h",
                             readback[7:0], color));
    end
  endtask

  // Random traffic. Most of it is text: runs of characters with newlines
  // mixed in, a few long enough to wrap. Around that come cursor moves,
  // direct writes often read back at once, random reads, rare clears and
  // the odd spare operation code. Out-of-screen positions show up too.
  task automatic drive_random_traffic(int quota);
    int sent;
    int pick;
    int run_len;
    console_op_t op;
    sent = 0;
    while (sent < quota) begin
      pick = $urandom_range(0, 99);
      op = scatter_op();
      if (pick < 58) begin
        run_len = ($urandom_range(0, 15) == 0) ? $urandom_range(60, 100)
                                                : $urandom_range(1, 40);
        for (int i = 0; i < run_len; i++) begin
          op = scatter_op();
          case ($urandom_range(0, 11))
            0:       op.ch = CH_NEWLINE;
            1:       op.ch = 8'($urandom_range(0, 255));
            default: op.ch = 8'($urandom_range(32, 126));
          endcase
          send_op(FUNC_PUT_CHAR, op, 1'b0, '0);
          sent++;
        end
      end else if (pick < 70) begin
        case ($urandom_range(0, 9))
          0:       op.x = 7'($urandom_range(0, 127));
          1:       op.x = 7'(COLS);
          default: op.x = 7'($urandom_range(0, COLS - 1));
        endcase
        case ($urandom_range(0, 9))
          0:       op.y = 5'($urandom_range(0, 31));
          1:       op.y = 5'(ROWS - 1);
          default: op.y = 5'($urandom_range(0, ROWS - 1));
        endcase
        send_op(FUNC_SET_CUR, op, 1'b0, '0);
        sent++;
      end else if (pick < 80) begin
        if ($urandom_range(0, 7) != 0) begin
          op.x = 7'($urandom_range(0, COLS - 1));
          op.y = 5'($urandom_range(0, ROWS - 1));
        end
        send_op(FUNC_WRITE, op, 1'b0, '0);
        sent++;
        if ($urandom_range(0, 1) == 1) begin
          send_op(FUNC_READ, op, 1'b0, '0);
          sent++;
        end
      end else if (pick < 94) begin
        if ($urandom_range(0, 5) != 0) begin
          op.x = 7'($urandom_range(0, COLS - 1));
          op.y = 5'($urandom_range(0, ROWS - 1));
        end
        send_op(FUNC_READ, op, 1'b0, '0);
        sent++;
      end else if (pick < 95) begin
        send_op(FUNC_CLEAR, op, 1'b0, '0);
        sent++;
      end else begin
        // Spare codes are ignored by the block and are not counted.
        send_op(3'($urandom_range(FUNC_SPARE_FIRST, FUNC_SPARE_LAST)), op, 1'b0, '0);
      end
    end
  endtask

  // Result side: every transfer on out_ is matched against the oldest
  // owed report, field by field.
  always @(posedge clk) begin
    console_report_t got;
    console_report_t want;
    if (rst_n && out_tvalid && out_tready) begin
      got = console_report_t'(out_tdata);
      reports_seen++;
      if (cursor_reports_q.size() == 0) begin
        report_error($sformatf("result %0d arrived with nothing owed: %h",
                               reports_seen, out_tdata));
      end else begin
        want = cursor_reports_q.pop_front();
        if (got.col != want.col || got.line != want.line ||
            got.cell_word != want.cell_word || got.scrolled != want.scrolled) begin
          report_error($sformatf(
            {"result %0d: expected col %0d line %0d cell %h scrolled %0d, ",
             "got col %0d line %0d cell %h scrolled %0d"},
            reports_seen, want.col, want.line, want.cell_word, want.scrolled,
            got.col, got.line, got.cell_word, got.scrolled));
        end
      end
    end
  end

  // Receiver: out_tready follows a pattern of its own, switching between
  // always ready, coin flips and fixed duty cycles. Once, after a few
  // hundred results, it holds off for a long stretch so that the output
  // register and the queue behind the decoder fill and in_tready drops.
  initial begin : result_receiver
    int mode;
    int span;
    int cyc;
    mode = 0;
    span = 0;
    cyc  = 0;
    out_tready = 1'b0;
    forever begin
      @(negedge clk);
      if (!long_hold_done && reports_seen >= 300) begin
        rx_hold = 1'b1;
        out_tready <= 1'b0;
        repeat (400) @(negedge clk);
        rx_hold = 1'b0;
        long_hold_done = 1'b1;
      end
      if (span == 0) begin
        mode = $urandom_range(0, 3);
        span = $urandom_range(16, 200);
      end
      span--;
      cyc++;
      case (mode)
        0:       out_tready <= 1'b1;
        1:       out_tready <= 1'($urandom_range(0, 1));
        2:       out_tready <= (cyc % 4 == 0);
        default: out_tready <= (cyc % 7 < 5);
      endcase
    end
  end

  // Main sequence: reset, the opening table at the reset attribute, then
  // random phases, each under a new attribute written while the block is
  // idle. The first two phases use the extremes of the attribute.
  initial begin : stimulus
    logic [7:0] color;
    console_op_t op;
    console_report_t typed_rep;
    in_tvalid   = 1'b0;
    in_tdata    = '0;
    in_tuser    = '0;
    cfg_psel    = 1'b0;
    cfg_penable = 1'b0;
    cfg_pwrite  = 1'b0;
    cfg_paddr   = '0;
    cfg_pwdata  = '0;
    rst_n       = 1'b0;
    text_color  = RESET_COLOR;
    caret_col   = 0;
    caret_row   = 0;
    for (int i = 0; i < CELLS; i++) begin
      screen_mirror[i] = RESET_BLANK;
    end
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // The block spends its first cycles clearing the store; in_tready
    // stays low until then, and send_op simply waits on it.
    foreach (opening_rows[r]) begin
      op = '0;
      op.ch   = opening_rows[r].ch;
      op.attr = opening_rows[r].attr;
      op.x    = opening_rows[r].x;
      op.y    = opening_rows[r].y;
      typed_rep = '{3'b0, opening_rows[r].scrolled, opening_rows[r].cell_word,
                    opening_rows[r].line, opening_rows[r].col};
      send_op(opening_rows[r].func, op, opening_rows[r].known, typed_rep);
    end
    settle_console();

    for (int phase = 0; phase < 5; phase++) begin
      case (phase)
        0:       color = 8'h00;
        1:       color = 8'hFF;
        default: color = 8'($urandom);
      endcase
      write_text_color(color);
      drive_random_traffic(ITEMS_PER_PHASE);
      settle_console();
    end

    // Anything the block sends from here on would be flagged as unowed.
    repeat (20) @(posedge clk);
    if (error_count == 0 && cursor_reports_q.size() == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

  // Watchdog: far beyond the slowest run this stimulus can take, counting
  // the clearing pass after reset and one full sweep per scroll or clear.
  initial begin : watchdog
    #30_000_000;
    $display("Simulation FAILED");
    $finish;
  end

endmodule
